// ----- rtl/mnis_pkg.sv -----
// Shared types and constants of the masked box index stepper.
package mnis_pkg;

    localparam int DIMS_DEF       = 3;
    localparam int COORD_BITS_DEF = 16;
    localparam int MAX_DIMS       = 3;
    localparam int CFG_ADDR_BITS  = 3;
    localparam int MASK_BITS      = 3;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_BITS-1:0] REG_LOWER_X     = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_UPPER_X     = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_ACTIVE_MASK = 3'd6;
    localparam logic [MASK_BITS-1:0]     ACTIVE_MASK_RST = 3'b111;

    // Request kinds carried in tuser.
    localparam logic REQ_ADVANCE = 1'b0;
    localparam logic REQ_LOAD    = 1'b1;

    typedef struct packed {
        logic advance;
        logic load;
        logic step_en;
        logic lower_we;
        logic upper_we;
    } t_cell_ctrl;

endpackage

// ----- rtl/mnis_cell.sv -----
// One dimension of the index: coordinate, bounds and the carry step.
module mnis_cell #(
    parameter int COORD_BITS = mnis_pkg::COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mnis_pkg::t_cell_ctrl  i_ctrl,
    input  logic [COORD_BITS-1:0] i_cfg_data,
    input  logic [COORD_BITS-1:0] i_load_value,
    input  logic                  i_carry,
    output logic                  o_carry,
    output logic [COORD_BITS-1:0] o_next_coord
);
    import mnis_pkg::*;

    logic [COORD_BITS-1:0] r_coord;
    logic [COORD_BITS-1:0] n_coord;
    logic [COORD_BITS-1:0] r_lower;
    logic [COORD_BITS-1:0] r_upper;
    logic [COORD_BITS:0]   w_inc;
    logic [COORD_BITS:0]   w_upper_ext;
    logic                  w_pass;
    logic                  w_step;

    // The increment is compared one bit wider, so the largest value always passes.
    assign w_inc       = {r_coord[COORD_BITS-1], r_coord} + (COORD_BITS+1)'(1);
    assign w_upper_ext = {r_upper[COORD_BITS-1], r_upper};
    assign w_pass      = $signed(w_inc) > $signed(w_upper_ext);
    assign w_step      = i_ctrl.advance && i_ctrl.step_en && i_carry;

    always_comb begin
        priority if (i_ctrl.load) begin
            n_coord = i_load_value;
        end else if (w_step) begin
            n_coord = w_pass ? r_lower : w_inc[COORD_BITS-1:0];
        end else begin
            n_coord = r_coord;
        end
    end

    // An inactive dimension passes the carry straight through.
    assign o_carry      = i_ctrl.step_en ? (i_carry && w_pass) : i_carry;
    assign o_next_coord = n_coord;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coord <= '0;
            r_lower <= '0;
            r_upper <= '0;
        end else begin
            r_coord <= n_coord;
            if (i_ctrl.lower_we) begin
                r_lower <= i_cfg_data;
            end
            if (i_ctrl.upper_we) begin
                r_upper <= i_cfg_data;
            end
        end
    end

endmodule

// ----- rtl/masked_nd_index_stepper.sv -----
// Top level of the masked box index stepper: cell chain and output register.
//
// Walks a three-coordinate box index the way nested loops do. Each request
// either loads a start index (tuser high) or advances the index by one step
// (tuser low), and each request yields exactly one result holding the new
// index and a wrapped flag. The user must write bounds and the active mask
// through the configuration port only while the block is idle; the block
// itself does not enforce this. One request is taken per clock cycle while
// the output side is ready or the output register is empty: the carry ripples
// through a chain of three dimension cells within the cycle, and one output
// register holds the result, valid from the cycle after the request is taken.
module masked_nd_index_stepper #(
    parameter int DIMS       = mnis_pkg::DIMS_DEF,
    parameter int COORD_BITS = mnis_pkg::COORD_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [mnis_pkg::CFG_ADDR_BITS-1:0]     i_cfg_addr,
    input  logic [COORD_BITS-1:0]                  i_cfg_data,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // start_x, start_y, start_z, zero padding
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
    // req_type
    input  logic                                   s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // index_x, index_y, index_z, zero padding
    output logic [((3*COORD_BITS+7)/8)*8-1:0]      m_axis_tdata,
    // wrapped
    output logic                                   m_axis_tuser
);
    import mnis_pkg::*;

    localparam int TDATA_W = ((3*COORD_BITS+7)/8)*8;
    localparam int PAD_W   = TDATA_W - 3*COORD_BITS;

    logic                  w_fire;
    logic                  w_carry [0:MAX_DIMS];
    logic [COORD_BITS-1:0] w_next  [0:MAX_DIMS-1];
    t_cell_ctrl            w_ctrl  [0:MAX_DIMS-1];
    logic [MASK_BITS-1:0]  r_active_mask;
    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_out_coord [0:MAX_DIMS-1];
    logic                  r_out_wrapped;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_fire        = s_axis_tvalid && s_axis_tready;
    assign w_carry[0]    = 1'b1;

    for (genvar d = 0; d < MAX_DIMS; d++) begin : g_cell
        always_comb begin
            w_ctrl[d].advance  = w_fire && (s_axis_tuser == REQ_ADVANCE);
            w_ctrl[d].load     = w_fire && (s_axis_tuser == REQ_LOAD);
            w_ctrl[d].step_en  = (d < DIMS) && r_active_mask[d];
            w_ctrl[d].lower_we = i_cfg_we && (i_cfg_addr == REG_LOWER_X + CFG_ADDR_BITS'(d));
            w_ctrl[d].upper_we = i_cfg_we && (i_cfg_addr == REG_UPPER_X + CFG_ADDR_BITS'(d));
        end

        mnis_cell #(
            .COORD_BITS (COORD_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl[d]),
            .i_cfg_data   (i_cfg_data),
            .i_load_value (s_axis_tdata[d*COORD_BITS +: COORD_BITS]),
            .i_carry      (w_carry[d]),
            .o_carry      (w_carry[d+1]),
            .o_next_coord (w_next[d])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_mask <= ACTIVE_MASK_RST;
        end else if (i_cfg_we && (i_cfg_addr == REG_ACTIVE_MASK)) begin
            r_active_mask <= i_cfg_data[MASK_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // A carry out of the top also covers the case of no active dimension.
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_coord[0] <= w_next[0];
            r_out_coord[1] <= w_next[1];
            r_out_coord[2] <= w_next[2];
            r_out_wrapped  <= (s_axis_tuser == REQ_ADVANCE) && w_carry[MAX_DIMS];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_wrapped;

    if (PAD_W > 0) begin : g_pad
        assign m_axis_tdata = {PAD_W'(0), r_out_coord[2], r_out_coord[1], r_out_coord[0]};
    end else begin : g_nopad
        assign m_axis_tdata = {r_out_coord[2], r_out_coord[1], r_out_coord[0]};
    end

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench of the masked box index stepper, with its scoreboard class.
import mnis_pkg::*;

typedef logic signed [COORD_BITS_DEF-1:0] coord_t;

typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   wrapped;
} box_index_t;

class index_tracker;
    coord_t         lower [MAX_DIMS];
    coord_t         upper [MAX_DIMS];
    logic [2:0]     mask;
    coord_t         idx [MAX_DIMS];
    box_index_t     expected_indexes [$];
    int             mismatches;
    int             results_seen;
    int             wraps_seen;

    function new();
        for (int d = 0; d < MAX_DIMS; d++) begin
            lower[d] = '0;
            upper[d] = '0;
            idx[d]   = '0;
        end
        mask         = ACTIVE_MASK_RST;
        mismatches   = 0;
        results_seen = 0;
        wraps_seen   = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_BITS-1:0] addr, logic [COORD_BITS_DEF-1:0] value);
        if (addr == REG_ACTIVE_MASK) begin
            mask = value[2:0];
        end else if (addr >= REG_UPPER_X) begin
            upper[addr - REG_UPPER_X] = value;
        end else begin
            lower[addr - REG_LOWER_X] = value;
        end
    endfunction

    function int pending();
        return expected_indexes.size();
    endfunction

    // Steps the mirrored index for one accepted request and queues the new index.
    function void take_request(logic kind, coord_t sx, coord_t sy, coord_t sz);
        box_index_t next;
        logic       carry;
        logic       any;
        int         bumped;
        next.wrapped = 1'b0;
        if (kind == REQ_LOAD) begin
            idx[0] = sx;
            idx[1] = sy;
            idx[2] = sz;
        end else begin
            carry = 1'b1;
            any   = 1'b0;
            for (int d = 0; d < DIMS_DEF; d++) begin
                if (mask[d]) begin
                    any = 1'b1;
                    if (carry) begin
                        // The bound test is done at full width, so the largest
                        // coordinate always passes its upper bound.
                        bumped = int'(idx[d]) + 1;
                        if (bumped > int'(upper[d])) begin
                            idx[d] = lower[d];
                        end else begin
                            idx[d] = coord_t'(bumped);
                            carry  = 1'b0;
                        end
                    end
                end
            end
            next.wrapped = !any || carry;
        end
        next.x = idx[0];
        next.y = idx[1];
        next.z = idx[2];
        expected_indexes.push_back(next);
    endfunction

    function void check_result(logic [3*COORD_BITS_DEF-1:0] data, logic flag);
        box_index_t want;
        coord_t     gx;
        coord_t     gy;
        coord_t     gz;
        gx = data[15:0];
        gy = data[31:16];
        gz = data[47:32];
        results_seen++;
        if (flag === 1'b1) wraps_seen++;
        if (expected_indexes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("tb_top: unexpected result x=%0d y=%0d z=%0d wrapped=%0b",
                         gx, gy, gz, flag);
            return;
        end
        want = expected_indexes.pop_front();
        if (gx !== want.x || gy !== want.y || gz !== want.z || flag !== want.wrapped) begin
            mismatches++;
            if (mismatches <= 10)
                $display("tb_top: result %0d expected x=%0d y=%0d z=%0d wrapped=%0b, got x=%0d y=%0d z=%0d wrapped=%0b",
                         results_seen, want.x, want.y, want.z, want.wrapped,
                         gx, gy, gz, flag);
        end
    endfunction
endclass

module tb_top;
    localparam int TDATA_W = ((3*COORD_BITS_DEF+7)/8)*8;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_ADDR_BITS-1:0] i_cfg_addr;
    logic [COORD_BITS_DEF-1:0] i_cfg_data;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [TDATA_W-1:0]       s_axis_tdata;
    logic                     s_axis_tuser;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [TDATA_W-1:0]       m_axis_tdata;
    logic                     m_axis_tuser;

    index_tracker tracker;
    logic         src_fast;
    logic         sink_fast;
    int           n_loads;
    int           n_advances;
    int           n_settings;

    masked_nd_index_stepper dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("tb_top: timeout");
        $display("tb_top: done, errors");
        $finish;
    end

    // Result side: after each accepted result, may drop ready for a random stall unless sink_fast is set.
    initial begin : result_sink
        int stall;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        m_axis_tready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                tracker.check_result(m_axis_tdata[3*COORD_BITS_DEF-1:0], m_axis_tuser);
                stall = sink_fast ? 0 : $urandom_range(0, 19);
                if (stall > 0) begin
                    @(negedge i_clk);
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(negedge i_clk);
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    function automatic coord_t pick_in_range(coord_t lo, coord_t hi);
        if (hi < lo) return lo;
        return coord_t'(int'(lo) + int'($urandom_range(0, int'(hi) - int'(lo))));
    endfunction

    // Called at a falling edge; returns at the falling edge after the request.
    task automatic send_request(input logic kind, input coord_t sx, input coord_t sy,
                                input coord_t sz);
        int gap;
        gap = src_fast ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {sz, sy, sx};
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.take_request(kind, sx, sy, sz);
        if (kind == REQ_LOAD) n_loads++;
        else n_advances++;
        @(negedge i_clk);
    endtask

    task automatic advance_steps(input int n);
        for (int k = 0; k < n; k++)
            send_request(REQ_ADVANCE, coord_t'($urandom), coord_t'($urandom),
                         coord_t'($urandom));
    endtask

    // Waits for the block to go idle, then rewrites every register.
    task automatic program_box(input coord_t lx, input coord_t ly, input coord_t lz,
                               input coord_t ux, input coord_t uy, input coord_t uz,
                               input logic [2:0] mask);
        logic [CFG_ADDR_BITS-1:0]  addrs [7];
        logic [COORD_BITS_DEF-1:0] vals [7];
        addrs = '{REG_LOWER_X, REG_LOWER_X + 3'd1, REG_LOWER_X + 3'd2,
                  REG_UPPER_X, REG_UPPER_X + 3'd1, REG_UPPER_X + 3'd2, REG_ACTIVE_MASK};
        vals  = '{lx, ly, lz, ux, uy, uz, {{(COORD_BITS_DEF-3){1'b0}}, mask}};
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
        for (int r = 0; r < 7; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_addr <= addrs[r];
            i_cfg_data <= vals[r];
            tracker.write_reg(addrs[r], vals[r]);
            @(negedge i_clk);
        end
        i_cfg_we  <= 1'b0;
        n_settings++;
        src_fast  = ($urandom_range(0, 3) == 0);
        sink_fast = ($urandom_range(0, 3) == 0);
    endtask

    initial begin : stimulus
        coord_t lo [3];
        coord_t hi [3];
        int     base;
        int     span;
        int     pick;
        tracker       = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_ADVANCE;
        src_fast      = 1'b0;
        sink_fast     = 1'b0;
        n_loads       = 0;
        n_advances    = 0;
        n_settings    = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset bounds are all zero, so an advance from the reset index carries out of the box.
        advance_steps(1);
        send_request(REQ_LOAD, 16'sh7FFF, 16'sh8000, 16'sh1234);
        advance_steps(1);

        // The top coordinate of z sits at the largest value and must wrap.
        program_box(-16'sd2, 16'sd0, 16'sd32766, 16'sd1, 16'sd2, 16'sd32767, 3'b111);
        send_request(REQ_LOAD, 16'sd1, 16'sd2, 16'sd32767);
        advance_steps(1);
        // Start outside the bounds: only the incremented value is tested.
        send_request(REQ_LOAD, -16'sd5, 16'sd5, 16'sd0);
        advance_steps(4);

        // No active dimension: index holds and every advance wraps.
        program_box(16'sd0, 16'sd0, 16'sd0, 16'sd9, 16'sd9, 16'sd9, 3'b000);
        send_request(REQ_LOAD, 16'sd3, 16'sd4, 16'sd5);
        advance_steps(2);

        // Upper below lower on x, with y inactive and carried over.
        program_box(16'sd5, -16'sd32768, 16'sd0, -16'sd3, 16'sd32767, 16'sd0, 3'b101);
        send_request(REQ_LOAD, 16'sd0, 16'sd100, 16'sd0);
        advance_steps(3);

        // Only y steps, over the full coordinate range.
        program_box(16'sd0, -16'sd32768, 16'sd0, 16'sd0, 16'sd32767, 16'sd0, 3'b010);
        send_request(REQ_LOAD, 16'sd9, 16'sd32767, -16'sd1);
        advance_steps(2);

        for (int ph = 0; ph < 10; ph++) begin
            for (int d = 0; d < 3; d++) begin
                base = int'($urandom_range(0, 65535)) - 32768;
                span = $urandom_range(0, 4);
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    lo[d] = 16'sh8000;
                    hi[d] = coord_t'(-32768 + span);
                end else if (pick == 1) begin
                    hi[d] = 16'sh7FFF;
                    lo[d] = coord_t'(32767 - span);
                end else if (pick == 2) begin
                    lo[d] = coord_t'(base);
                    hi[d] = coord_t'(base - 1 - span);
                end else begin
                    lo[d] = coord_t'(base);
                    hi[d] = coord_t'(base + span);
                end
            end
            program_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], 3'($urandom_range(0, 7)));
            send_request(REQ_LOAD, pick_in_range(lo[0], hi[0]), pick_in_range(lo[1], hi[1]),
                         pick_in_range(lo[2], hi[2]));
            for (int k = 0; k < 54; k++) begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    send_request(REQ_LOAD, coord_t'($urandom), coord_t'($urandom),
                                 coord_t'($urandom));
                else if (pick == 1)
                    send_request(REQ_LOAD, pick_in_range(lo[0], hi[0]),
                                 pick_in_range(lo[1], hi[1]), pick_in_range(lo[2], hi[2]));
                else
                    advance_steps(1);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
        repeat (5) @(negedge i_clk);
        $display("tb_top: %0d requests (%0d loads, %0d advances) across %0d bound settings",
                 n_loads + n_advances, n_loads, n_advances, n_settings + 1);
        $display("tb_top: %0d results checked, %0d wrapped, %0d mismatches",
                 tracker.results_seen, tracker.wraps_seen, tracker.mismatches);
        if (tracker.mismatches == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule
